// File: rtl/cdvs_pkg.sv
// cdvs_pkg: types, constants and helper functions of the critically damped value smoother
// used by cdvs_front, cdvs_queue, cdvs_back and critically_damped_value_smoother_core

package cdvs_pkg;

   // channel count and index width
   localparam int CHANNELS  = 8;
   localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CHAN_IN_W = 3;

   // value format: signed Q7.24
   localparam int DW        = 32;
   localparam int FRAC      = 24;
   localparam int DELTA_W   = DW + 1;

   // coefficient registers
   localparam int RATIO_W   = 26;
   localparam int DECAY_W   = 25;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DW    = RATIO_W;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_RATIO = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_DECAY      = 1'b1;
   localparam logic [RATIO_W-1:0]   STEP_RATIO_RST = RATIO_W'(13981);
   localparam logic [DECAY_W-1:0]   DECAY_RST      = DECAY_W'(16763000);

   // shared multiplier: signed operand split in two halves, unsigned coefficient
   localparam int AW         = 40;
   localparam int HALF       = AW / 2;
   localparam int BW         = RATIO_W;
   localparam int CHUNK_W    = HALF + 1;
   localparam int BOP_W      = BW + 1;
   localparam int PROD_W     = CHUNK_W + BOP_W;
   localparam int ACC_W      = 68;
   localparam int RND_W      = ACC_W - FRAC;
   localparam int ROUND_HALF = 1 << (FRAC - 1);

   // item queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QP_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

   // kind field codes
   localparam logic [1:0] KIND_STEP    = 2'd0;
   localparam logic [1:0] KIND_SET     = 2'd1;
   localparam logic [1:0] KIND_SET_ALL = 2'd2;

   typedef enum logic [1:0] {
      OP_STEP    = 2'd0,
      OP_SET     = 2'd1,
      OP_SET_ALL = 2'd2
   } op_type;

   typedef struct packed {
      op_type                op;
      logic [CH_W-1:0]       ch;
      logic signed [DW-1:0]  tgt;
   } item_type;

   // queue head as seen by the back end
   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   // channel index wrapped into the channel count
   function automatic logic [CH_W-1:0] chan_wrap(input logic [CHAN_IN_W-1:0] c);
      logic [CHAN_IN_W-1:0] v;
      v = c;
      for (int i = 0; i < (1 << CHAN_IN_W) - 1; i++) begin
         if (int'(v) >= CHANNELS) begin
            v = v - CHAN_IN_W'(CHANNELS);
         end
      end
      return CH_W'(v);
   endfunction

   // clamp to the signed 32-bit range
   function automatic logic signed [DW-1:0] sat32(input logic signed [RND_W-1:0] v);
      logic in_range;
      in_range = (v[RND_W-1:DW-1] == '0) || (v[RND_W-1:DW-1] == '1);
      if (in_range) begin
         return v[DW-1:0];
      end else if (v[RND_W-1]) begin
         return {1'b1, {(DW-1){1'b0}}};
      end else begin
         return {1'b0, {(DW-1){1'b1}}};
      end
   endfunction

endpackage

// File: rtl/critically_damped_value_smoother_core.sv
// critically_damped_value_smoother_core: top level of the critically damped value smoother
// depends on cdvs_pkg, cdvs_front, cdvs_queue and cdvs_back
//
//   channel  direction  handshake          payload
//   req      in         valid / stall      kind, channel, target
//   rsp      out        valid / stall      out_channel, smoothed
//   csr      in         valid / ready      index, wdata (step_ratio, decay_factor)
//
// a step item goes from queue head to result register as four products on the
// one shared multiplier, each as two half-width partial products, a sum and a follow-up
// a set or set-all item is applied in the load state; unused kinds are taken and dropped at the front
// a two-item queue lets req take up to two items while the back end works or rsp is stalled
// reset is synchronous and clears all levels and rates and restores the coefficient defaults
// csr writes are taken every cycle and are meant for idle periods

module critically_damped_value_smoother_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_kind,
   input  logic [cdvs_pkg::CHAN_IN_W-1:0]    req_channel,
   input  logic signed [cdvs_pkg::DW-1:0]    req_target,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [cdvs_pkg::CHAN_IN_W-1:0]    rsp_out_channel,
   output logic signed [cdvs_pkg::DW-1:0]    rsp_smoothed,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cdvs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cdvs_pkg::CSR_DW-1:0]       csr_wdata
);
   import cdvs_pkg::*;

   logic     q_full;
   logic     push;
   item_type push_item;
   logic     pop;
   head_type head;

   assign csr_ready = 1'b1;

   cdvs_front u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_kind    (req_kind),
      .req_channel (req_channel),
      .req_target  (req_target),
      .q_full      (q_full),
      .push        (push),
      .push_item   (push_item)
   );

   cdvs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (pop),
      .head      (head)
   );

   cdvs_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .pop             (pop),
      .csr_we          (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_channel (rsp_out_channel),
      .rsp_smoothed    (rsp_smoothed)
   );

endmodule

// File: rtl/cdvs_queue.sv
// cdvs_queue: short item queue between the front end and the back end
// depends on cdvs_pkg

module cdvs_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  cdvs_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output cdvs_pkg::head_type head
);
   import cdvs_pkg::*;

   item_type          slot_ff [QUEUE_DEPTH];
   item_type          slot_in [QUEUE_DEPTH];
   logic [QP_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QP_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QC_W-1:0]   count_ff, count_in;

   always_comb begin
      slot_in   = slot_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         slot_in[wr_ptr_ff] = push_item;
         wr_ptr_in = (wr_ptr_ff == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign full       = (count_ff == QC_W'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.item  = slot_ff[rd_ptr_ff];

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != QC_W'(QUEUE_DEPTH)))
      else $error("item pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("item popped from an empty queue");
`endif

endmodule

// File: rtl/cdvs_front.sv
// cdvs_front: accepts request items, decodes the kind and wraps the channel index
// depends on cdvs_pkg; feeds cdvs_queue

module cdvs_front (
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_kind,
   input  logic [cdvs_pkg::CHAN_IN_W-1:0] req_channel,
   input  logic signed [cdvs_pkg::DW-1:0] req_target,
   input  logic                          q_full,
   output logic                          push,
   output cdvs_pkg::item_type            push_item
);
   import cdvs_pkg::*;

   logic known;

   always_comb begin
      known         = 1'b1;
      push_item.op  = OP_STEP;
      push_item.ch  = chan_wrap(req_channel);
      push_item.tgt = req_target;
      case (req_kind)
         KIND_STEP:    push_item.op = OP_STEP;
         KIND_SET:     push_item.op = OP_SET;
         KIND_SET_ALL: push_item.op = OP_SET_ALL;
         default:      known = 1'b0;
      endcase
   end

   // unused kind is taken and dropped here
   assign req_stall = q_full;
   assign push      = req_valid && !q_full && known;

endmodule

// File: rtl/cdvs_back.sv
// cdvs_back: per-channel level and rate stores, coefficient registers, sequencer around
// one shared split multiplier, and the result register; depends on cdvs_pkg

module cdvs_back (
   input  logic                             clock,
   input  logic                             reset,
   input  cdvs_pkg::head_type               head,
   output logic                             pop,
   input  logic                             csr_we,
   input  logic [cdvs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cdvs_pkg::CSR_DW-1:0]      csr_wdata,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [cdvs_pkg::CHAN_IN_W-1:0]   rsp_out_channel,
   output logic signed [cdvs_pkg::DW-1:0]   rsp_smoothed
);
   import cdvs_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_LOAD = 7'b0000010,
      ST_MLO  = 7'b0000100,
      ST_MHI  = 7'b0001000,
      ST_SUM  = 7'b0010000,
      ST_FIN  = 7'b0100000,
      ST_DONE = 7'b1000000
   } state_type;

   // which product is in flight
   typedef enum logic [3:0] {
      PH_XD = 4'b0001,
      PH_XT = 4'b0010,
      PH_KE = 4'b0100,
      PH_DE = 4'b1000
   } phase_type;

   state_type                  state_ff, state_in;
   phase_type                  phase_ff, phase_in;
   logic [RATIO_W-1:0]         step_ratio_ff, step_ratio_in;
   logic [DECAY_W-1:0]         decay_ff, decay_in;
   logic signed [DW-1:0]       level_ff [CHANNELS];
   logic signed [DW-1:0]       level_in [CHANNELS];
   logic signed [DW-1:0]       rate_ff  [CHANNELS];
   logic signed [DW-1:0]       rate_in  [CHANNELS];
   logic                       rsp_valid_ff, rsp_valid_in;

   item_type                   item_ff, item_in;
   logic signed [DELTA_W-1:0]  delta_ff, delta_in;
   logic signed [DW-1:0]       rate_cur_ff, rate_cur_in;
   logic signed [AW-1:0]       temp_ff, temp_in;
   logic signed [DW-1:0]       rate_new_ff, rate_new_in;
   logic signed [AW-1:0]       a_ff, a_in;
   logic [BW-1:0]              b_ff, b_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [RND_W-1:0]    round_ff, round_in;
   logic [CHAN_IN_W-1:0]       res_ch_ff, res_ch_in;
   logic signed [DW-1:0]       res_val_ff, res_val_in;
   logic [CHAN_IN_W-1:0]       rsp_ch_ff, rsp_ch_in;
   logic signed [DW-1:0]       rsp_val_ff, rsp_val_in;

   logic signed [CHUNK_W-1:0]  mul_chunk;
   logic signed [BOP_W-1:0]    mul_b;
   logic signed [PROD_W-1:0]   mul_p;
   logic signed [ACC_W-1:0]    sum_w;
   logic signed [RND_W-1:0]    wide_w;
   logic signed [DW-1:0]       lvl_w;
   logic                       was_above, now_above;
   logic                       out_free;

   // low half unsigned first, then the signed high half
   assign mul_chunk = (state_ff == ST_MHI) ? $signed({a_ff[AW-1], a_ff[AW-1:HALF]})
                                           : $signed({1'b0, a_ff[HALF-1:0]});
   assign mul_b     = $signed({1'b0, b_ff});
   assign mul_p     = mul_chunk * mul_b;
   assign sum_w     = (ACC_W'(prod_ff) <<< HALF) + acc_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      step_ratio_in = step_ratio_ff;
      decay_in      = decay_ff;
      level_in      = level_ff;
      rate_in       = rate_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      item_in       = item_ff;
      delta_in      = delta_ff;
      rate_cur_in   = rate_cur_ff;
      temp_in       = temp_ff;
      rate_new_in   = rate_new_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      round_in      = round_ff;
      res_ch_in     = res_ch_ff;
      res_val_in    = res_val_ff;
      rsp_ch_in     = rsp_ch_ff;
      rsp_val_in    = rsp_val_ff;
      pop           = 1'b0;
      wide_w        = '0;
      lvl_w         = '0;
      was_above     = 1'b0;
      now_above     = 1'b0;

      if (csr_we) begin
         case (csr_index)
            REG_STEP_RATIO: step_ratio_in = csr_wdata[RATIO_W-1:0];
            REG_DECAY:      decay_in      = csr_wdata[DECAY_W-1:0];
            default:        ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop      = 1'b1;
               item_in  = head.item;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            case (item_ff.op)
               OP_STEP: begin
                  delta_in    = DELTA_W'(level_ff[item_ff.ch]) - DELTA_W'(item_ff.tgt);
                  rate_cur_in = rate_ff[item_ff.ch];
                  a_in        = AW'(DELTA_W'(level_ff[item_ff.ch]) - DELTA_W'(item_ff.tgt));
                  b_in        = step_ratio_ff;
                  phase_in    = PH_XD;
                  state_in    = ST_MLO;
               end
               OP_SET: begin
                  level_in[item_ff.ch] = item_ff.tgt;
                  rate_in[item_ff.ch]  = '0;
                  res_ch_in  = CHAN_IN_W'(item_ff.ch);
                  res_val_in = item_ff.tgt;
                  state_in   = ST_DONE;
               end
               OP_SET_ALL: begin
                  for (int c = 0; c < CHANNELS; c++) begin
                     level_in[c] = item_ff.tgt;
                     rate_in[c]  = '0;
                  end
                  res_ch_in  = '0;
                  res_val_in = item_ff.tgt;
                  state_in   = ST_DONE;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_MLO: begin
            prod_in  = mul_p;
            state_in = ST_MHI;
         end
         ST_MHI: begin
            // rounding bias folded in: halves away from zero, then floor
            acc_in   = ACC_W'(prod_ff) + ACC_W'(ROUND_HALF) - ACC_W'(a_ff[AW-1]);
            prod_in  = mul_p;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            round_in = sum_w[ACC_W-1:FRAC];
            state_in = ST_FIN;
         end
         ST_FIN: begin
            state_in = ST_MLO;
            case (phase_ff)
               PH_XD: begin
                  wide_w   = RND_W'(rate_cur_ff) + round_ff;
                  temp_in  = AW'(wide_w);
                  a_in     = AW'(wide_w);
                  b_in     = step_ratio_ff;
                  phase_in = PH_XT;
               end
               PH_XT: begin
                  wide_w   = RND_W'(rate_cur_ff) - round_ff;
                  a_in     = AW'(wide_w);
                  b_in     = BW'(decay_ff);
                  phase_in = PH_KE;
               end
               PH_KE: begin
                  rate_new_in = sat32(round_ff);
                  a_in        = AW'(delta_ff) + temp_ff;
                  b_in        = BW'(decay_ff);
                  phase_in    = PH_DE;
               end
               PH_DE: begin
                  wide_w    = RND_W'(item_ff.tgt) + round_ff;
                  lvl_w     = sat32(wide_w);
                  was_above = (delta_ff > 0);
                  now_above = (lvl_w > item_ff.tgt);
                  res_ch_in = CHAN_IN_W'(item_ff.ch);
                  // crossing the target snaps onto it and stops the motion
                  if (was_above == now_above) begin
                     level_in[item_ff.ch] = lvl_w;
                     rate_in[item_ff.ch]  = rate_new_ff;
                     res_val_in           = lvl_w;
                  end else begin
                     level_in[item_ff.ch] = item_ff.tgt;
                     rate_in[item_ff.ch]  = '0;
                     res_val_in           = item_ff.tgt;
                  end
                  state_in = ST_DONE;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ch_in    = res_ch_ff;
               rsp_val_in   = res_val_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= PH_XD;
         step_ratio_ff <= STEP_RATIO_RST;
         decay_ff      <= DECAY_RST;
         rsp_valid_ff  <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) begin
            level_ff[c] <= '0;
            rate_ff[c]  <= '0;
         end
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         step_ratio_ff <= step_ratio_in;
         decay_ff      <= decay_in;
         rsp_valid_ff  <= rsp_valid_in;
         level_ff      <= level_in;
         rate_ff       <= rate_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      delta_ff    <= delta_in;
      rate_cur_ff <= rate_cur_in;
      temp_ff     <= temp_in;
      rate_new_ff <= rate_new_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      round_ff    <= round_in;
      res_ch_ff   <= res_ch_in;
      res_val_ff  <= res_val_in;
      rsp_ch_ff   <= rsp_ch_in;
      rsp_val_ff  <= rsp_val_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_channel = rsp_ch_ff;
   assign rsp_smoothed    = rsp_val_ff;

`ifndef SYNTHESIS
   a_high_half_after_low: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MHI) |-> ($past(state_ff) == ST_MLO))
      else $error("high partial product without low partial product");

   a_set_loads_channel: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD && item_ff.op == OP_SET) |=>
         (rate_ff[item_ff.ch] == '0 && level_ff[item_ff.ch] == item_ff.tgt))
      else $error("set item did not load its channel");

   a_done_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !out_free) |=> (state_ff == ST_DONE))
      else $error("result dropped while the output register was held");

   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_free) |=>
         (rsp_valid_ff && rsp_val_ff == $past(res_val_ff)))
      else $error("finished result not presented");
`endif

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking testbench of critically_damped_value_smoother_core
// depends on cdvs_pkg and the core; predicts each result with its own spring model, or takes it from the directed row

module tb_top;
   import cdvs_pkg::*;

   localparam logic [1:0] KIND_UNUSED  = 2'd3;
   localparam int         CYCLE_LIMIT  = 1_000_000;
   localparam int         SETTLE_CYCLES = 64;
   localparam int         LONG_HOLD    = 400;
   localparam int         PHASE_ITEMS  = 275;
   localparam longint     HALF_LSB     = longint'(1) <<< (FRAC - 1);
   localparam logic [RATIO_W-1:0] RATIO_MAX = '1;
   localparam logic [CSR_DW-1:0]  DECAY_ONE = CSR_DW'(1 << FRAC);
   localparam logic signed [DW-1:0] LEVEL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DW-1:0] LEVEL_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic [CHAN_IN_W-1:0] chan;
      logic signed [DW-1:0] level;
   } level_result_type;

   typedef struct packed {
      logic [1:0]           kind;
      logic [CHAN_IN_W-1:0] chan;
      logic [DW-1:0]        target;
      logic                 typed;
      logic [CHAN_IN_W-1:0] want_chan;
      logic [DW-1:0]        want_level;
   } directed_row_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [1:0]                  req_kind = KIND_STEP;
   logic [CHAN_IN_W-1:0]        req_channel = '0;
   logic signed [DW-1:0]        req_target = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [CHAN_IN_W-1:0]        rsp_out_channel;
   logic signed [DW-1:0]        rsp_smoothed;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [CSR_IDX_W-1:0]        csr_index = REG_STEP_RATIO;
   logic [CSR_DW-1:0]           csr_wdata = '0;

   // model state and coefficients
   logic signed [DW-1:0] levels [CHANNELS];
   logic signed [DW-1:0] rates [CHANNELS];
   logic [RATIO_W-1:0]   ratio_q = STEP_RATIO_RST;
   logic [DECAY_W-1:0]   decay_q = DECAY_RST;

   level_result_type expected_levels [$];
   int  errors = 0;
   int  items_sent = 0;
   int  results_checked = 0;
   int  snaps = 0;
   int  saturations = 0;
   int  settings_used = 1;
   int  long_holds = 0;
   int  burst_left = 0;
   int  cycles = 0;
   bit  long_hold_req = 1'b0;

   directed_row_type directed_rows [22] = '{
      '{KIND_STEP,    3'd0, 32'h0000_0000, 1'b1, 3'd0, 32'h0000_0000},
      '{KIND_SET,     3'd1, 32'h7FFF_FFFF, 1'b1, 3'd1, 32'h7FFF_FFFF},
      '{KIND_STEP,    3'd1, 32'h8000_0000, 1'b0, 3'd0, 32'h0},
      '{KIND_STEP,    3'd1, 32'h8000_0000, 1'b0, 3'd0, 32'h0},
      '{KIND_SET,     3'd2, 32'h8000_0000, 1'b1, 3'd2, 32'h8000_0000},
      '{KIND_STEP,    3'd2, 32'h7FFF_FFFF, 1'b0, 3'd0, 32'h0},
      '{KIND_SET_ALL, 3'd5, 32'h1234_5678, 1'b1, 3'd0, 32'h1234_5678},
      '{KIND_STEP,    3'd7, 32'h1234_5678, 1'b1, 3'd7, 32'h1234_5678},
      '{KIND_UNUSED,  3'd3, 32'hA5A5_A5A5, 1'b0, 3'd0, 32'h0},
      '{KIND_STEP,    3'd3, 32'h0100_0000, 1'b0, 3'd0, 32'h0},
      '{KIND_STEP,    3'd3, 32'h0100_0000, 1'b0, 3'd0, 32'h0},
      '{KIND_SET,     3'd4, 32'h0000_0000, 1'b1, 3'd4, 32'h0000_0000},
      '{KIND_STEP,    3'd4, 32'h7FFF_FFFF, 1'b0, 3'd0, 32'h0},
      '{KIND_STEP,    3'd4, 32'h7FFF_FFFF, 1'b0, 3'd0, 32'h0},
      '{KIND_SET,     3'd6, 32'hFFFF_FFFF, 1'b1, 3'd6, 32'hFFFF_FFFF},
      '{KIND_STEP,    3'd6, 32'h0000_0000, 1'b0, 3'd0, 32'h0},
      '{KIND_UNUSED,  3'd7, 32'h7FFF_FFFF, 1'b0, 3'd0, 32'h0},
      '{KIND_SET_ALL, 3'd2, 32'h8000_0000, 1'b1, 3'd0, 32'h8000_0000},
      '{KIND_STEP,    3'd0, 32'h7FFF_FFFF, 1'b0, 3'd0, 32'h0},
      '{KIND_STEP,    3'd5, 32'h8000_0000, 1'b1, 3'd5, 32'h8000_0000},
      '{KIND_SET,     3'd3, 32'h0080_0000, 1'b1, 3'd3, 32'h0080_0000},
      '{KIND_STEP,    3'd3, 32'hFF80_0000, 1'b0, 3'd0, 32'h0}
   };

   critically_damped_value_smoother_core uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_channel     (req_channel),
      .req_target      (req_target),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_channel (rsp_out_channel),
      .rsp_smoothed    (rsp_smoothed),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // product scaled back to q24, halves away from zero
   function automatic longint round_to_q24(input longint v);
      longint mag;
      if (v >= 0) begin
         return (v + HALF_LSB) >>> FRAC;
      end
      mag = -v;
      return -((mag + HALF_LSB) >>> FRAC);
   endfunction

   function automatic logic signed [DW-1:0] clamp_level(input longint v);
      if (v > longint'(LEVEL_MAX)) begin
         return LEVEL_MAX;
      end else if (v < longint'(LEVEL_MIN)) begin
         return LEVEL_MIN;
      end
      return DW'(v);
   endfunction

   // applies one item to the channel state, returns 0 when no result follows
   function automatic bit advance_smoother(input logic [1:0] kind,
                                           input logic [CHAN_IN_W-1:0] chan,
                                           input logic signed [DW-1:0] target,
                                           output level_result_type res);
      int idx;
      longint x, e, tgt, rate, delta, temp, raw;
      logic signed [DW-1:0] lvl;
      idx = int'(chan) % CHANNELS;
      x = longint'(ratio_q);
      e = longint'(decay_q);
      tgt = longint'(target);
      res = '0;
      case (kind)
         KIND_STEP: begin
            rate = longint'(rates[idx]);
            delta = longint'(levels[idx]) - tgt;
            temp = rate + round_to_q24(x * delta);
            raw = tgt + round_to_q24((delta + temp) * e);
            lvl = clamp_level(raw);
            if (raw != longint'(lvl)) saturations++;
            // crossing the target snaps onto it and kills the velocity
            if ((delta > 0) == (longint'(lvl) > tgt)) begin
               levels[idx] = lvl;
               rates[idx] = clamp_level(round_to_q24((rate - round_to_q24(x * temp)) * e));
            end else begin
               levels[idx] = target;
               rates[idx] = '0;
               snaps++;
            end
            res.chan = CHAN_IN_W'(idx);
            res.level = levels[idx];
         end
         KIND_SET: begin
            levels[idx] = target;
            rates[idx] = '0;
            res.chan = CHAN_IN_W'(idx);
            res.level = target;
         end
         KIND_SET_ALL: begin
            for (int c = 0; c < CHANNELS; c++) begin
               levels[c] = target;
               rates[c] = '0;
            end
            res.level = target;
         end
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   task automatic send_item(input logic [1:0] kind, input logic [CHAN_IN_W-1:0] chan,
                            input logic [DW-1:0] target, input logic typed,
                            input logic [CHAN_IN_W-1:0] want_chan,
                            input logic [DW-1:0] want_level);
      level_result_type res;
      req_valid <= 1'b1;
      req_kind <= kind;
      req_channel <= chan;
      req_target <= target;
      do @(posedge clock); while (req_stall);
      if (advance_smoother(kind, chan, target, res)) begin
         if (typed) begin
            res.chan = want_chan;
            res.level = want_level;
         end
         expected_levels.push_back(res);
      end
      if (kind != KIND_UNUSED) items_sent++;
   endtask

   // sender bursts with random gaps between them
   task automatic offer(input logic [1:0] kind, input logic [CHAN_IN_W-1:0] chan,
                        input logic [DW-1:0] target);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      send_item(kind, chan, target, 1'b0, '0, '0);
   endtask

   task automatic wait_all_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_levels.size() != 0);
      burst_left = 0;
   endtask

   task automatic load_coeffs(input logic [CSR_DW-1:0] ratio_word,
                              input logic [CSR_DW-1:0] decay_word);
      wait_all_results();
      // an unused kind may still be in flight with nothing left to wait for
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= REG_STEP_RATIO;
      csr_wdata <= ratio_word;
      do @(posedge clock); while (!csr_ready);
      ratio_q = ratio_word[RATIO_W-1:0];
      csr_index <= REG_DECAY;
      csr_wdata <= decay_word;
      do @(posedge clock); while (!csr_ready);
      decay_q = decay_word[DECAY_W-1:0];
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [DW-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return LEVEL_MIN;
         1: return LEVEL_MAX;
         2: return '0;
         3: return DW'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
         default: return $urandom();
      endcase
   endfunction

   // mostly set-then-approach trajectories, some single items and noise
   task automatic run_random_phase(input int quota, input bit with_hold, input bit with_pause);
      int first;
      int pick;
      int n;
      logic [CHAN_IN_W-1:0] chan;
      logic [DW-1:0] start_val;
      logic [DW-1:0] goal;
      first = items_sent;
      if (with_hold) long_hold_req = 1'b1;
      while (items_sent - first < quota) begin
         if (with_pause && (items_sent - first >= quota / 2)) begin
            with_pause = 1'b0;
            wait_all_results();
         end
         pick = $urandom_range(0, 99);
         chan = CHAN_IN_W'($urandom_range(0, 7));
         if (pick < 5) begin
            offer(KIND_SET_ALL, chan, pick_value());
         end else if (pick < 9) begin
            offer(KIND_UNUSED, chan, $urandom());
         end else if (pick < 18) begin
            offer(2'($urandom_range(0, 1)), chan, pick_value());
         end else begin
            start_val = pick_value();
            if ($urandom_range(0, 2) != 0) begin
               offer(KIND_SET, chan, start_val);
            end else begin
               start_val = levels[chan];
            end
            if ($urandom_range(0, 2) == 0) begin
               goal = pick_value();
            end else begin
               goal = start_val + DW'(int'($urandom_range(0, 1 << 26)) - (1 << 25));
            end
            n = $urandom_range(1, 24);
            repeat (n) offer(KIND_STEP, chan, goal);
         end
      end
   endtask

   // result side: check, then pick the next stall value
   initial begin
      level_result_type want;
      int stall_pct;
      int mode_left;
      int hold_left;
      stall_pct = 0;
      mode_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (expected_levels.size() == 0) begin
               $error("unexpected item: out_channel %0d smoothed %0h",
                      rsp_out_channel, rsp_smoothed);
               errors++;
            end else begin
               want = expected_levels.pop_front();
               if (rsp_out_channel !== want.chan) begin
                  $error("out_channel: expected %0d, actual %0d", want.chan, rsp_out_channel);
                  errors++;
               end
               if (rsp_smoothed !== want.level) begin
                  $error("smoothed: expected %0h, actual %0h", want.level, rsp_smoothed);
                  errors++;
               end
               results_checked++;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD - 1;
            long_holds++;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               mode_left = $urandom_range(4, 80);
               case ($urandom_range(0, 3))
                  0: stall_pct = 0;
                  1: stall_pct = 25;
                  2: stall_pct = 50;
                  default: stall_pct = 85;
               endcase
            end
            mode_left--;
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   initial begin
      logic [CSR_DW-1:0] decay_word;
      for (int c = 0; c < CHANNELS; c++) begin
         levels[c] = '0;
         rates[c] = '0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (burst_left == 0) burst_left = $urandom_range(1, 8);
         burst_left--;
         send_item(directed_rows[i].kind, directed_rows[i].chan, directed_rows[i].target,
                   directed_rows[i].typed, directed_rows[i].want_chan,
                   directed_rows[i].want_level);
      end

      // slow, realistic smoothing
      load_coeffs(CSR_DW'($urandom_range(1000, 1 << 21)),
                  DECAY_ONE - CSR_DW'($urandom_range(0, 1 << 19)));
      run_random_phase(PHASE_ITEMS, 1'b1, 1'b0);
      load_coeffs(CSR_DW'(RATIO_MAX), '0);
      run_random_phase(PHASE_ITEMS, 1'b0, 1'b0);
      load_coeffs('0, DECAY_ONE);
      run_random_phase(PHASE_ITEMS, 1'b0, 1'b0);
      // all-ones decay word: upper bit dropped, largest decay above one
      load_coeffs(CSR_DW'($urandom_range(0, RATIO_MAX)), '1);
      run_random_phase(PHASE_ITEMS, 1'b0, 1'b0);
      load_coeffs(CSR_DW'(STEP_RATIO_RST), CSR_DW'(DECAY_RST));
      run_random_phase(PHASE_ITEMS, 1'b0, 1'b1);
      load_coeffs(CSR_DW'($urandom()), CSR_DW'($urandom()));
      run_random_phase(PHASE_ITEMS, 1'b0, 1'b0);
      decay_word = DECAY_ONE + CSR_DW'($urandom_range(1, 1 << 20));
      load_coeffs(CSR_DW'($urandom_range(1 << 22, 1 << 24)), decay_word);
      run_random_phase(PHASE_ITEMS, 1'b1, 1'b0);

      wait_all_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_levels.size() != 0) begin
         $error("%0d expected items never arrived", expected_levels.size());
         errors += expected_levels.size();
      end
      $display("covered %0d items over %0d coefficient settings, %0d results checked",
               items_sent, settings_used, results_checked);
      $display("saw %0d snaps to target, %0d saturated levels, %0d long output holds",
               snaps, saturations, long_holds);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
